/* design/hdf_pkg.sv */
// ----------------------------------------------------------------------------
// Hex dump formatter package
// Shared transfer types, queue sizing, character codes and the digit function.
// ----------------------------------------------------------------------------
package hdf_pkg;

	localparam int GROUP_BYTES = 4;
	localparam int BLOCK_BYTES = 16;
	localparam int LINE_BYTES  = 32;

	localparam int POS_W       = 5;
	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
	localparam int STEP_W      = 6;

	localparam logic [7:0] CH_SPACE  = 8'h20;
	localparam logic [7:0] CH_LF     = 8'h0A;
	localparam logic [7:0] CH_ZERO   = 8'h30;
	localparam logic [7:0] CH_LETTER = 8'h41;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       final_byte;
	} data_item_t;

	typedef struct packed {
		logic [7:0] out_char;
		logic       run_last;
		logic       dump_end;
	} text_item_t;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       final_byte;
		logic       sep_line;
		logic       sep_block;
		logic       sep_group;
	} desc_t;

	typedef struct packed {
		logic  avail;
		logic  full;
		desc_t head;
	} queue_stat_t;

	function automatic logic [7:0] nibble_char(input logic [3:0] v);
		logic [7:0] ch;
		if (v < 4'd10) begin
			ch = CH_ZERO + {4'd0, v};
		end else begin
			ch = CH_LETTER + {4'd0, v - 4'd10};
		end
		return ch;
	endfunction

endpackage

/* design/hdf_front.sv */
// ----------------------------------------------------------------------------
// Hex dump formatter front end
// Accepts input bytes, tracks the dump position and decides the separators.
// ----------------------------------------------------------------------------
module hdf_front (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               data_valid,
	input  hdf_pkg::data_item_t data,
	input  logic               queue_full,
	output logic               push,
	output hdf_pkg::desc_t     desc
);
	import hdf_pkg::*;

	logic [POS_W-1:0] pos_q;
	logic             started_q;

	assign push = data_valid && !queue_full;

	always_comb begin
		desc.data_byte  = data.data_byte;
		desc.final_byte = data.final_byte;
		desc.sep_group  = started_q && ((pos_q % GROUP_BYTES) == 0);
		desc.sep_block  = started_q && ((pos_q % BLOCK_BYTES) == 0);
		desc.sep_line   = started_q && ((pos_q % LINE_BYTES) == 0);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q     <= '0;
			started_q <= 1'b0;
		end else if (push) begin
			if (data.final_byte) begin
				pos_q     <= '0;
				started_q <= 1'b0;
			end else begin
				pos_q     <= pos_q + 1'b1;
				started_q <= 1'b1;
			end
		end
	end

endmodule

/* design/hdf_queue.sv */
// ----------------------------------------------------------------------------
// Hex dump formatter queue
// Short first-in first-out buffer of classified bytes between front and back.
// ----------------------------------------------------------------------------
module hdf_queue (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  push,
	input  hdf_pkg::desc_t        wr_desc,
	input  logic                  pop,
	output hdf_pkg::queue_stat_t  stat
);
	import hdf_pkg::*;

	desc_t             entries_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QPTR_W:0]   count_q;

	always_comb begin
		stat.avail = (count_q != '0);
		stat.full  = (count_q == QUEUE_DEPTH[QPTR_W:0]);
		stat.head  = entries_q[rd_ptr_q];
	end

	always_ff @(posedge clk) begin
		if (push) begin
			entries_q[wr_ptr_q] <= wr_desc;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			unique case ({push, pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

/* design/hdf_back.sv */
// ----------------------------------------------------------------------------
// Hex dump formatter back end
// Expands each classified byte into its characters, one per cycle while text_stall is low.
// ----------------------------------------------------------------------------
module hdf_back (
	input  logic                 clk,
	input  logic                 arst_n,
	input  hdf_pkg::queue_stat_t stat,
	output logic                 pop,
	output logic                 text_valid,
	input  logic                 text_stall,
	output hdf_pkg::text_item_t  text
);
	import hdf_pkg::*;

	logic [STEP_W-1:0] mask_q;
	logic [7:0]        data_q;
	logic              fin_q;
	logic              text_valid_q;
	text_item_t        text_q;

	logic [STEP_W-1:0] low;
	logic [STEP_W-1:0] rest;
	logic              advance;
	logic              emit;
	text_item_t        nxt;

	assign text_valid = text_valid_q;
	assign text       = text_q;

	always_comb begin
		low     = mask_q & (~mask_q + 1'b1);
		rest    = mask_q & ~low;
		advance = !text_valid_q || !text_stall;
		emit    = advance && (mask_q != '0);
		pop     = stat.avail && ((mask_q == '0) || (emit && (rest == '0)));

		nxt = '{out_char: CH_LF, run_last: 1'b1, dump_end: 1'b1};
		priority case (1'b1)
			low[0]:  nxt = '{out_char: CH_SPACE, run_last: 1'b0, dump_end: 1'b0};
			low[1]:  nxt = '{out_char: CH_SPACE, run_last: 1'b0, dump_end: 1'b0};
			low[2]:  nxt = '{out_char: CH_LF, run_last: 1'b0, dump_end: 1'b0};
			low[3]:  nxt = '{out_char: nibble_char(data_q[7:4]), run_last: 1'b0,
				dump_end: 1'b0};
			low[4]:  nxt = '{out_char: nibble_char(data_q[3:0]), run_last: !fin_q,
				dump_end: 1'b0};
			default: nxt = '{out_char: CH_LF, run_last: 1'b1, dump_end: 1'b1};
		endcase
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			text_q <= nxt;
		end
		if (pop) begin
			data_q <= stat.head.data_byte;
			fin_q  <= stat.head.final_byte;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mask_q       <= '0;
			text_valid_q <= 1'b0;
		end else begin
			if (pop) begin
				mask_q <= {stat.head.final_byte, 1'b1, 1'b1, stat.head.sep_line,
					stat.head.sep_block, stat.head.sep_group};
			end else if (emit) begin
				mask_q <= rest;
			end
			if (emit) begin
				text_valid_q <= 1'b1;
			end else if (advance) begin
				text_valid_q <= 1'b0;
			end
		end
	end

endmodule

/* design/hex_dump_formatter_unit.sv */
// ----------------------------------------------------------------------------
// Hex dump formatter unit
// Renders a byte stream as upper-case hex text with group and line spacing.
// ----------------------------------------------------------------------------
// Bytes arrive on the data channel (data_valid, data_stall, data) and each
// transfer carries one byte and a flag that marks the last byte of a dump.
// Characters leave on the text channel (text_valid, text_stall, text), one
// character per transfer, flagged on the last character of each byte and on
// the closing line feed of a dump.
// A byte yields two to six characters; the single output register sets the
// rate at one character per cycle while text_stall is low. The first
// character of a byte that meets an idle back end passes through the queue,
// the character mask register and the output register. A four-entry queue
// sits between the front end and the character sequencer, so bytes keep
// being taken while text waits. When text_stall is high the presented
// character holds; once the queue is full, data_stall rises. Reset empties
// the queue, drops text_valid and starts a new dump at position zero.
// ----------------------------------------------------------------------------
module hex_dump_formatter_unit (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                data_valid,
	output logic                data_stall,
	input  hdf_pkg::data_item_t data,
	output logic                text_valid,
	input  logic                text_stall,
	output hdf_pkg::text_item_t text
);
	import hdf_pkg::*;

	logic        push;
	logic        pop;
	desc_t       desc;
	queue_stat_t stat;

	assign data_stall = stat.full;

	hdf_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.data_valid (data_valid),
		.data       (data),
		.queue_full (stat.full),
		.push       (push),
		.desc       (desc)
	);

	hdf_queue u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (push),
		.wr_desc (desc),
		.pop     (pop),
		.stat    (stat)
	);

	hdf_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.stat       (stat),
		.pop        (pop),
		.text_valid (text_valid),
		.text_stall (text_stall),
		.text       (text)
	);

endmodule

/* design/hdf_checker.sv */
// ----------------------------------------------------------------------------
// Hex dump formatter checker
// Port-level properties of the formatter, attached to the top level by bind.
// ----------------------------------------------------------------------------
module hdf_checker (
	input logic                clk,
	input logic                arst_n,
	input logic                data_valid,
	input logic                data_stall,
	input hdf_pkg::data_item_t data,
	input logic                text_valid,
	input logic                text_stall,
	input hdf_pkg::text_item_t text
);
	import hdf_pkg::*;

	a_data_hold: assert property (@(posedge clk) disable iff (!arst_n)
		data_valid && data_stall |=> data_valid && $stable(data))
		else $error("stalled data transfer changed or dropped");

	a_text_hold: assert property (@(posedge clk) disable iff (!arst_n)
		text_valid && text_stall |=> text_valid && $stable(text))
		else $error("stalled text transfer changed or dropped");

	a_end_is_lf: assert property (@(posedge clk) disable iff (!arst_n)
		text_valid && text.dump_end |-> text.run_last && (text.out_char == CH_LF))
		else $error("dump end not on a closing line feed");

	a_char_set: assert property (@(posedge clk) disable iff (!arst_n)
		text_valid |-> (text.out_char == CH_SPACE) || (text.out_char == CH_LF) ||
			((text.out_char >= 8'h30) && (text.out_char <= 8'h39)) ||
			((text.out_char >= 8'h41) && (text.out_char <= 8'h46)))
		else $error("character outside the hex dump set");

	a_byte_end_digit: assert property (@(posedge clk) disable iff (!arst_n)
		text_valid && text.run_last && !text.dump_end |->
			(text.out_char != CH_SPACE) && (text.out_char != CH_LF))
		else $error("byte ended on a separator");

endmodule

bind hex_dump_formatter_unit hdf_checker u_hdf_checker (.*);

/* sim/tb_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Hex dump formatter testbench
// Sends byte dumps with random pacing and checks every character of the text.
// ----------------------------------------------------------------------------
// Each accepted byte transfer is run through a local model of the formatter.
// The model keeps its own position and dump state and queues the characters
// that the byte should produce. Every text transfer is compared with the
// oldest queued character. Both channels idle at random in most stretches.
// ----------------------------------------------------------------------------
module tb_top;
	import hdf_pkg::*;

	localparam int CYCLE_LIMIT  = 200000;
	localparam int DRAIN_CYCLES = 16;
	localparam int MAX_REPORTS  = 10;
	localparam int BYTE_TARGET  = 500;
	localparam logic [0:15][7:0] HEX_GLYPHS = "0123456789ABCDEF";

	logic       clk        = 1'b0;
	logic       arst_n     = 1'b0;
	logic       data_valid = 1'b0;
	logic       data_stall;
	data_item_t data       = '0;
	logic       text_valid;
	logic       text_stall = 1'b0;
	text_item_t text;

	text_item_t       pending_chars[$];
	logic [POS_W-1:0] next_pos   = '0;
	logic             dump_open  = 1'b0;
	logic             char_taken = 1'b0;
	bit               pacing_on  = 1'b1;
	int               bytes_sent = 0;
	int               mismatches = 0;
	int               stall_left = 0;
	int               cycles     = 0;

	hex_dump_formatter_unit dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.data_valid(data_valid),
		.data_stall(data_stall),
		.data      (data),
		.text_valid(text_valid),
		.text_stall(text_stall),
		.text      (text)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("== FAIL ==");
			$finish;
		end
	end

	function automatic text_item_t make_char(input logic [7:0] ch, input logic last,
			input logic closing);
		text_item_t c;
		c.out_char = ch;
		c.run_last = last;
		c.dump_end = closing;
		return c;
	endfunction

	task automatic note_mismatch(input string what);
		mismatches++;
		if (mismatches <= MAX_REPORTS) begin
			$display("%s", what);
		end
	endtask

	// Queue the characters that one accepted byte produces.
	task automatic predict_text(input data_item_t item);
		if (dump_open) begin
			if (next_pos % GROUP_BYTES == 0) begin
				pending_chars.push_back(make_char(CH_SPACE, 1'b0, 1'b0));
			end
			if (next_pos % BLOCK_BYTES == 0) begin
				pending_chars.push_back(make_char(CH_SPACE, 1'b0, 1'b0));
			end
			if (next_pos % LINE_BYTES == 0) begin
				pending_chars.push_back(make_char(CH_LF, 1'b0, 1'b0));
			end
		end
		pending_chars.push_back(make_char(HEX_GLYPHS[item.data_byte[7:4]], 1'b0, 1'b0));
		pending_chars.push_back(make_char(HEX_GLYPHS[item.data_byte[3:0]],
			!item.final_byte, 1'b0));
		if (item.final_byte) begin
			pending_chars.push_back(make_char(CH_LF, 1'b1, 1'b1));
			next_pos  = '0;
			dump_open = 1'b0;
		end else begin
			next_pos  = next_pos + 1'b1;
			dump_open = 1'b1;
		end
	endtask

	task automatic send_byte(input logic [7:0] value, input logic last_of_dump);
		int         gap;
		data_item_t item;
		gap = pacing_on ? $urandom_range(0, 3) : 0;
		item.data_byte  = value;
		item.final_byte = last_of_dump;
		if (gap > 0) begin
			@(negedge clk);
			data_valid <= 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
		@(negedge clk);
		data       <= item;
		data_valid <= 1'b1;
		do @(posedge clk); while (data_stall);
		predict_text(item);
		bytes_sent++;
	endtask

	task automatic send_dump(input int len);
		for (int i = 0; i < len; i++) begin
			send_byte(8'($urandom_range(0, 255)), i == len - 1);
		end
	endtask

	always @(posedge clk) begin : check_text
		text_item_t want;
		char_taken <= arst_n && text_valid && !text_stall;
		if (arst_n && text_valid && !text_stall) begin
			if (pending_chars.size() == 0) begin
				note_mismatch($sformatf("unexpected character: got %h/%b/%b",
					text.out_char, text.run_last, text.dump_end));
			end else begin
				want = pending_chars.pop_front();
				if (text.out_char !== want.out_char || text.run_last !== want.run_last ||
						text.dump_end !== want.dump_end) begin
					note_mismatch($sformatf("character mismatch: expected %h/%b/%b, got %h/%b/%b",
						want.out_char, want.run_last, want.dump_end,
						text.out_char, text.run_last, text.dump_end));
				end
			end
		end
	end

	always @(negedge clk) begin
		if (char_taken) begin
			stall_left = pacing_on ? $urandom_range(0, 3) : 0;
		end
		if (stall_left > 0) begin
			text_stall <= 1'b1;
			stall_left = stall_left - 1;
		end else begin
			text_stall <= 1'b0;
		end
	end

	task automatic test_single_byte_dumps();
		pacing_on = 1'b1;
		send_byte(8'h00, 1'b1);
		send_byte(8'hFF, 1'b1);
		send_byte(8'h5A, 1'b1);
	endtask

	task automatic test_all_nibbles();
		logic [3:0] nib;
		for (int i = 0; i < 16; i++) begin
			nib = 4'(i);
			send_byte({nib, ~nib}, i == 15);
		end
	endtask

	task automatic test_long_dumps();
		pacing_on = 1'b1;
		send_dump(33);
		send_dump(65);
	endtask

	task automatic test_back_to_back();
		pacing_on = 1'b0;
		send_dump(40);
		send_dump(1);
		send_dump(20);
	endtask

	task automatic test_random_dumps();
		int len;
		while (bytes_sent < BYTE_TARGET) begin
			pacing_on = ($urandom_range(0, 7) != 0);
			len = ($urandom_range(0, 4) == 0) ? $urandom_range(33, 96) : $urandom_range(1, 32);
			send_dump(len);
		end
	endtask

	initial begin
		repeat (9) @(negedge clk);
		arst_n <= 1'b1;
		test_single_byte_dumps();
		test_all_nibbles();
		test_long_dumps();
		test_back_to_back();
		test_random_dumps();
		@(negedge clk);
		data_valid <= 1'b0;
		while (pending_chars.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatches == 0) begin
			$display("== PASS ==");
		end else begin
			$display("== FAIL ==");
		end
		$finish;
	end

endmodule

/* filelist.f */
design/hdf_pkg.sv
design/hdf_front.sv
design/hdf_queue.sv
design/hdf_back.sv
design/hex_dump_formatter_unit.sv
design/hdf_checker.sv
sim/tb_top.sv
